/* rtl/avgc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automatic volume gain control: shared package
// Types, register indexes, reset values and step counts used by the block.
// ----------------------------------------------------------------------------
package avgc_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned THR_W    = 15;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned WLEN_W   = 16;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Widths of the serial arithmetic units.
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned MUL_A_W   = 32;
    localparam int unsigned MUL_B_W   = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W + 1);

    // Q12 gain fixed point and the eight-bit ratio scaling.
    localparam int unsigned GAIN_FRAC = 12;
    localparam int unsigned RATIO_SH  = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd2;

    // Reset values.
    localparam logic [THR_W-1:0]  RST_LEVEL_THRESHOLD = 15'd1125;
    localparam logic [GAIN_W-1:0] RST_NOMINAL_GAIN    = 16'd8192;
    localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH   = 16'd48000;
    localparam logic [GAIN_W-1:0] RST_CURRENT_GAIN    = 16'd4096;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_DIV_RATIO,
        ST_MUL_GAIN,
        ST_MUL_START,
        ST_MUL_OUT,
        ST_EMIT
    } t_state;

endpackage

/* rtl/avgc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automatic volume gain control: input sample channel
// Valid/ready channel that carries one signed audio sample per word.
// ----------------------------------------------------------------------------
interface avgc_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [avgc_pkg::SAMPLE_W-1:0]      sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

/* rtl/avgc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automatic volume gain control: output sample channel
// Valid/ready channel that carries one gain-scaled sample per word.
// ----------------------------------------------------------------------------
interface avgc_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [avgc_pkg::SAMPLE_W-1:0]      sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

/* rtl/avgc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automatic volume gain control: bit-serial divider
// Unsigned restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module avgc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [avgc_pkg::DIV_W-1:0]       i_dividend,
    input  logic [avgc_pkg::DIV_W-1:0]       i_divisor,
    output logic                             o_done,
    output logic [avgc_pkg::DIV_W-1:0]       o_quotient
);

    logic [avgc_pkg::DIV_W-1:0]     r_rem;
    logic [avgc_pkg::DIV_W-1:0]     r_quo;
    logic [avgc_pkg::DIV_W-1:0]     r_dsr;
    logic [avgc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;

    logic [avgc_pkg::DIV_W:0]       trial;
    logic [avgc_pkg::DIV_W:0]       diff;
    logic                           fits;

    // One restoring step: shift the next dividend bit into the remainder.
    always_comb begin
        trial = {r_rem, r_quo[avgc_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = (trial >= {1'b0, r_dsr});
    end

    // The quotient register doubles as the dividend shift register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= avgc_pkg::DIV_CNT_W'(avgc_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == avgc_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[avgc_pkg::DIV_W-1:0] : trial[avgc_pkg::DIV_W-1:0];
            r_quo <= {r_quo[avgc_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/avgc_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automatic volume gain control: bit-serial multiplier
// Shift-and-add multiplier that consumes one multiplier bit per cycle and
// keeps the low bits of the product.
// ----------------------------------------------------------------------------
module avgc_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [avgc_pkg::MUL_A_W-1:0]     i_a,
    input  logic [avgc_pkg::MUL_B_W-1:0]     i_b,
    output logic                             o_done,
    output logic [avgc_pkg::MUL_A_W-1:0]     o_product
);

    logic [avgc_pkg::MUL_A_W-1:0]   r_acc;
    logic [avgc_pkg::MUL_A_W-1:0]   r_a;
    logic [avgc_pkg::MUL_B_W-1:0]   r_b;
    logic [avgc_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                           r_done;

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= avgc_pkg::MUL_CNT_W'(avgc_pkg::MUL_B_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == avgc_pkg::MUL_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Add the shifted multiplicand when the current multiplier bit is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_cnt != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[avgc_pkg::MUL_A_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[avgc_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

/* rtl/auto_volume_gain_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automatic volume gain control
// Scales each audio sample by a Q12 gain that is recomputed from the average
// absolute level at the end of every window.
//
//   Channel      Direction  Payload              Handshake
//   i_sample_ch  in         sample_in  (s16)     valid / ready
//   o_sample_ch  out        sample_out (s16)     valid / ready
//   cfg port     in         i_cfg_data (u16)     i_cfg_we, index i_cfg_idx
//
// A sample that does not close a window is scaled by a serial multiply and
// sequencing before its output word is valid; the next sample is taken only
// after that word is loaded into the output register. A sample that closes a
// window adds a serial divide for the average and, when the level is above the
// threshold, a ratio divide and a gain multiply. A word still waiting at the
// output holds the block.
// Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module auto_volume_gain_control (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    avgc_in_if.sink                               i_sample_ch,
    avgc_out_if.source                            o_sample_ch,
    input  logic                                  i_cfg_we,
    input  logic [avgc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [avgc_pkg::CFG_W-1:0]            i_cfg_data
);

    // Configuration registers.
    logic [avgc_pkg::THR_W-1:0]    r_thr;
    logic [avgc_pkg::GAIN_W-1:0]   r_nom;
    logic [avgc_pkg::WLEN_W-1:0]   r_wlen;

    // Level tracking state.
    avgc_pkg::t_state              r_state, n_state;
    logic [avgc_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [avgc_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [avgc_pkg::GAIN_W-1:0]   r_gain, n_gain;
    logic [avgc_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic                          r_out_valid, n_out_valid;
    logic [avgc_pkg::SAMPLE_W-1:0] r_out_data, n_out_data;

    // Arithmetic unit connections.
    logic                          div_start;
    logic [avgc_pkg::DIV_W-1:0]    div_a;
    logic [avgc_pkg::DIV_W-1:0]    div_b;
    logic                          div_done;
    logic [avgc_pkg::DIV_W-1:0]    div_q;
    logic                          mul_start;
    logic [avgc_pkg::MUL_A_W-1:0]  mul_a;
    logic [avgc_pkg::MUL_B_W-1:0]  mul_b;
    logic                          mul_done;
    logic [avgc_pkg::MUL_A_W-1:0]  mul_p;

    logic [avgc_pkg::WLEN_W-1:0]   wlen_div;

    // Absolute value of a sample; the most negative one gives 32768.
    function automatic logic [avgc_pkg::SUM_W-1:0] sample_mag(
        input logic [avgc_pkg::SAMPLE_W-1:0] s
    );
        logic [avgc_pkg::SAMPLE_W:0] ext;
        ext = {s[avgc_pkg::SAMPLE_W-1], s};
        if (s[avgc_pkg::SAMPLE_W-1]) begin
            ext = '0 - ext;
        end
        return avgc_pkg::SUM_W'(ext);
    endfunction

    avgc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    avgc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    // A zero window length divides by one.
    assign wlen_div = (r_wlen == '0) ? avgc_pkg::WLEN_W'(1) : r_wlen;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= avgc_pkg::RST_LEVEL_THRESHOLD;
            r_nom  <= avgc_pkg::RST_NOMINAL_GAIN;
            r_wlen <= avgc_pkg::RST_WINDOW_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                avgc_pkg::CFG_LEVEL_THRESHOLD: r_thr  <= i_cfg_data[avgc_pkg::THR_W-1:0];
                avgc_pkg::CFG_NOMINAL_GAIN:    r_nom  <= i_cfg_data;
                avgc_pkg::CFG_WINDOW_LENGTH:   r_wlen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= avgc_pkg::ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_gain      <= avgc_pkg::RST_CURRENT_GAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_out_data <= n_out_data;
    end

    // Sequencer: window close, gain update, output multiply and emit.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_gain      = r_gain;
        n_sample    = r_sample;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        div_start   = 1'b0;
        div_a       = r_sum;
        div_b       = avgc_pkg::DIV_W'(wlen_div);
        mul_start   = 1'b0;
        mul_a       = avgc_pkg::MUL_A_W'($signed(r_sample));
        mul_b       = r_gain;

        // The output word leaves when the sink takes it.
        if (r_out_valid && o_sample_ch.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            avgc_pkg::ST_IDLE: begin
                if (i_sample_ch.valid) begin
                    n_sample = i_sample_ch.sample_in;
                    if (r_count >= avgc_pkg::COUNT_W'(r_wlen)) begin
                        div_start = 1'b1;
                        n_state   = avgc_pkg::ST_DIV_AVG;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + sample_mag(i_sample_ch.sample_in);
                        n_state = avgc_pkg::ST_MUL_START;
                    end
                end
            end
            avgc_pkg::ST_DIV_AVG: begin
                if (div_done) begin
                    if (div_q > avgc_pkg::DIV_W'(r_thr)) begin
                        div_start = 1'b1;
                        div_a     = avgc_pkg::DIV_W'({r_thr, {avgc_pkg::RATIO_SH{1'b0}}});
                        div_b     = div_q;
                        n_state   = avgc_pkg::ST_DIV_RATIO;
                    end else begin
                        n_gain  = r_nom;
                        n_count = '0;
                        n_sum   = sample_mag(r_sample);
                        n_state = avgc_pkg::ST_MUL_START;
                    end
                end
            end
            avgc_pkg::ST_DIV_RATIO: begin
                // The ratio stays below 256, so its low bits are enough.
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = avgc_pkg::MUL_A_W'(r_nom);
                    mul_b     = div_q[avgc_pkg::MUL_B_W-1:0];
                    n_state   = avgc_pkg::ST_MUL_GAIN;
                end
            end
            avgc_pkg::ST_MUL_GAIN: begin
                if (mul_done) begin
                    n_gain  = mul_p[avgc_pkg::RATIO_SH +: avgc_pkg::GAIN_W];
                    n_count = '0;
                    n_sum   = sample_mag(r_sample);
                    n_state = avgc_pkg::ST_MUL_START;
                end
            end
            avgc_pkg::ST_MUL_START: begin
                mul_start = 1'b1;
                n_state   = avgc_pkg::ST_MUL_OUT;
            end
            avgc_pkg::ST_MUL_OUT: begin
                if (mul_done) begin
                    n_state = avgc_pkg::ST_EMIT;
                end
            end
            avgc_pkg::ST_EMIT: begin
                if (!r_out_valid || o_sample_ch.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = mul_p[avgc_pkg::GAIN_FRAC +: avgc_pkg::SAMPLE_W];
                    n_state     = avgc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = avgc_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_sample_ch.ready      = (r_state == avgc_pkg::ST_IDLE);
    assign o_sample_ch.valid      = r_out_valid;
    assign o_sample_ch.sample_out = r_out_data;

endmodule

/* test/tb_auto_volume_gain_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the automatic volume gain control
// A directed table exercises the sample extremes, every register and the
// window corner cases: a window shortened below the running count, a zero
// window and gains of zero and full scale. Random phases follow. Each phase
// writes a new register setting and then sends a run of samples. Every output
// word is checked in order against a typed result or a local model of the
// level average and the gain update. Both channels insert random gaps.
// ----------------------------------------------------------------------------
module tb_auto_volume_gain_control;

    localparam int unsigned CLK_HALF      = 4;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned RANDOM_WORDS  = 500;
    localparam int unsigned QUIET_CYCLES  = 4;
    localparam int unsigned SETTLE_CYCLES = 150;
    localparam int unsigned IDLE_LIMIT    = 3000;

    // Index 3 is not mapped to any register; writes to it must be ignored.
    localparam logic [avgc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    // One directed row: a sample (optionally with a typed result) or a write.
    typedef struct packed {
        t_row_kind                           kind;
        logic [avgc_pkg::CFG_IDX_W-1:0]      idx;
        logic [avgc_pkg::CFG_W-1:0]          value;
        logic                                typed;
        logic [avgc_pkg::SAMPLE_W-1:0]       want;
    } t_dir_row;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [avgc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [avgc_pkg::CFG_W-1:0]     cfg_data;

    avgc_in_if  in_ch ();
    avgc_out_if out_ch ();

    auto_volume_gain_control u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample_ch (in_ch),
        .o_sample_ch (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Model copy of the registers and the gain state.
    logic [avgc_pkg::THR_W-1:0]    thr_reg;
    logic [avgc_pkg::GAIN_W-1:0]   nom_reg;
    logic [avgc_pkg::WLEN_W-1:0]   wlen_reg;
    logic [avgc_pkg::COUNT_W-1:0]  win_cnt;
    logic [avgc_pkg::SUM_W-1:0]    lvl_sum;
    logic [avgc_pkg::GAIN_W-1:0]   cur_gain;

    logic [avgc_pkg::SAMPLE_W-1:0] scaled_q [$];
    t_dir_row                      dir_rows [$];
    int unsigned                   error_count;
    int unsigned                   idle_cycles;
    int unsigned                   stall_left;
    bit                            calm;

    always #(CLK_HALF) clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Advance the level model by one sample and return the scaled word.
    function automatic logic [avgc_pkg::SAMPLE_W-1:0] predict_scaled(
        input logic [avgc_pkg::SAMPLE_W-1:0] smp
    );
        logic [31:0] mag;
        logic [31:0] divisor;
        logic [31:0] avg;
        logic [31:0] ratio;
        logic [31:0] prod;
        mag = smp[avgc_pkg::SAMPLE_W-1] ? (32'h1_0000 - {16'h0, smp}) : {16'h0, smp};
        // A full window closes before this sample is added; it is then not counted.
        if (win_cnt >= {1'b0, wlen_reg}) begin
            divisor = (wlen_reg == '0) ? 32'd1 : {16'h0, wlen_reg};
            avg     = lvl_sum / divisor;
            if (avg > {17'h0, thr_reg}) begin
                ratio    = ({17'h0, thr_reg} << avgc_pkg::RATIO_SH) / avg;
                prod     = (ratio * {16'h0, nom_reg}) >> avgc_pkg::RATIO_SH;
                cur_gain = prod[avgc_pkg::GAIN_W-1:0];
            end else begin
                cur_gain = nom_reg;
            end
            win_cnt = '0;
            lvl_sum = '0;
        end else begin
            win_cnt = win_cnt + 1'b1;
        end
        lvl_sum = lvl_sum + mag;
        prod    = {{16{smp[avgc_pkg::SAMPLE_W-1]}}, smp} * {16'h0, cur_gain};
        return prod[avgc_pkg::GAIN_FRAC +: avgc_pkg::SAMPLE_W];
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [avgc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [avgc_pkg::CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            avgc_pkg::CFG_LEVEL_THRESHOLD: thr_reg  = data[avgc_pkg::THR_W-1:0];
            avgc_pkg::CFG_NOMINAL_GAIN:    nom_reg  = data;
            avgc_pkg::CFG_WINDOW_LENGTH:   wlen_reg = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one sample word and queue its expected output once accepted.
    // Valid is left high so back-to-back words need no extra assignment.
    task automatic send_sample(input logic [avgc_pkg::SAMPLE_W-1:0] smp, input logic typed,
                               input logic [avgc_pkg::SAMPLE_W-1:0] want);
        int unsigned                   gap;
        logic [avgc_pkg::SAMPLE_W-1:0] model_out;
        gap = pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= smp;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        model_out = predict_scaled(smp);
        scaled_q.push_back(typed ? want : model_out);
    endtask

    // Hold the sender until every expected word has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (scaled_q.size() != 0);
    endtask

    // Output side: random back-pressure and in-order checking.
    always @(posedge clk) begin : rx_side
        logic [avgc_pkg::SAMPLE_W-1:0] want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (scaled_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d", $signed(out_ch.sample_out)));
            end else begin
                want = scaled_q.pop_front();
                if (out_ch.sample_out !== want)
                    report_mismatch($sformatf("sample_out got %0d want %0d",
                                              $signed(out_ch.sample_out), $signed(want)));
            end
        end
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // Watchdog: end the run when no word moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned                   sent;
        int unsigned                   phase_len;
        logic [avgc_pkg::CFG_W-1:0]    data;
        logic [avgc_pkg::SAMPLE_W-1:0] smp;

        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = avgc_pkg::CFG_LEVEL_THRESHOLD;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        out_ch.ready    = 1'b0;
        error_count     = 0;
        idle_cycles     = 0;
        stall_left      = 0;
        calm            = 1'b0;
        thr_reg         = avgc_pkg::RST_LEVEL_THRESHOLD;
        nom_reg         = avgc_pkg::RST_NOMINAL_GAIN;
        wlen_reg        = avgc_pkg::RST_WINDOW_LENGTH;
        win_cnt         = '0;
        lvl_sum         = '0;
        cur_gain        = avgc_pkg::RST_CURRENT_GAIN;

        // Directed rows. The index field of a sample row is unused.
        // Unity gain after reset passes each sample through unchanged.
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h0000, 1'b1, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h7FFF, 1'b1, 16'h7FFF});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h8000, 1'b1, 16'h8000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'hFFFF, 1'b1, 16'hFFFF});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h0001, 1'b1, 16'h0001});
        dir_rows.push_back('{ROW_WRITE,  CFG_UNMAPPED,                  16'hFFFF, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h5555, 1'b1, 16'h5555});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'hAAAA, 1'b1, 16'hAAAA});
        // Window shortened below the count: the next sample closes it at once.
        dir_rows.push_back('{ROW_WRITE,  avgc_pkg::CFG_WINDOW_LENGTH,   16'd3, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'd100, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'hFED4, 1'b0, 16'h0000});
        // Zero window length: every sample closes a window.
        dir_rows.push_back('{ROW_WRITE,  avgc_pkg::CFG_WINDOW_LENGTH,   16'd0, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h8000, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h7FFF, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h0000, 1'b0, 16'h0000});
        // Largest threshold and gain.
        dir_rows.push_back('{ROW_WRITE,  avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h7FFF, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_WRITE,  avgc_pkg::CFG_NOMINAL_GAIN,    16'hFFFF, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h7FFF, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h8000, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'd12345, 1'b0, 16'h0});
        // Zero gain silences the output whatever the level.
        dir_rows.push_back('{ROW_WRITE,  avgc_pkg::CFG_NOMINAL_GAIN,    16'h0000, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'd20000, 1'b1, 16'h0});
        dir_rows.push_back('{ROW_WRITE,  avgc_pkg::CFG_LEVEL_THRESHOLD, 16'h0000, 1'b0, 16'h0000});
        dir_rows.push_back('{ROW_SAMPLE, avgc_pkg::CFG_LEVEL_THRESHOLD, 16'hFFFB, 1'b1, 16'h0000});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                wait_drained();
                repeat (QUIET_CYCLES) @(posedge clk);
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end else begin
                send_sample(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random phases: a fresh register setting, then a run of samples.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            wait_drained();
            repeat (QUIET_CYCLES) @(posedge clk);

            case ($urandom_range(0, 9))
                0:          data = '0;
                1:          data = 16'h7FFF;
                2, 3, 4, 5: data = avgc_pkg::CFG_W'($urandom_range(0, 3000));
                default:    data = avgc_pkg::CFG_W'($urandom_range(0, 16'h7FFF));
            endcase
            write_reg(avgc_pkg::CFG_LEVEL_THRESHOLD, data);

            case ($urandom_range(0, 9))
                0:       data = '0;
                1:       data = 16'hFFFF;
                2, 3:    data = 16'd4096;
                default: data = avgc_pkg::CFG_W'($urandom_range(0, 16'hFFFF));
            endcase
            write_reg(avgc_pkg::CFG_NOMINAL_GAIN, data);

            // Mostly short windows so they close often; long ones carry the
            // count into the next phase.
            case ($urandom_range(0, 19))
                0:       data = '0;
                1:       data = 16'hFFFF;
                2, 3:    data = avgc_pkg::CFG_W'($urandom_range(100, 600));
                default: data = avgc_pkg::CFG_W'($urandom_range(1, 24));
            endcase
            write_reg(avgc_pkg::CFG_WINDOW_LENGTH, data);

            calm      = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(15, 50);
            for (int unsigned k = 0; k < phase_len; k++) begin
                if (sent == RANDOM_WORDS / 4 || $urandom_range(0, 99) == 0) wait_drained();
                case ($urandom_range(0, 9))
                    0: smp = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                    1: smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    2, 3, 4: begin
                        smp = avgc_pkg::SAMPLE_W'($urandom_range(0, 2000));
                        if ($urandom_range(0, 1)) smp = -smp;
                    end
                    default: smp = avgc_pkg::SAMPLE_W'($urandom_range(0, 16'hFFFF));
                endcase
                send_sample(smp, 1'b0, '0);
                sent++;
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
